>>> src/ssek_pkg.sv
package ssek_pkg;

   // Width of the running prefix and of the stored keys.
   localparam int DATA_WIDTH    = 32;
   // Number of cells in the prefix table.
   localparam int TABLE_ENTRIES = 64;
   localparam int ELEM_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 16;
   localparam int TOTAL_WIDTH   = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

   typedef struct packed {
      logic signed [ELEM_WIDTH-1:0] element_value;
      logic                         array_start;
      logic                         array_end;
   } req_type;

   typedef struct packed {
      logic [TOTAL_WIDTH-1:0] match_total;
      logic                   table_overflow;
      logic                   final_result;
   } rsp_type;

   // One element on its way down the cell chain.
   typedef struct packed {
      logic                   valid;
      logic                   start;
      logic                   last;
      logic [DATA_WIDTH-1:0]  prefix;
      logic [DATA_WIDTH-1:0]  want;
      logic [COUNT_WIDTH-1:0] match;
      logic                   found;
   } beat_type;

   // Sign-extends a 32-bit two's complement value and fits it to DATA_WIDTH.
   function automatic logic [DATA_WIDTH-1:0] widen_elem(input logic signed [ELEM_WIDTH-1:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[DATA_WIDTH-1:0];
   endfunction

endpackage

>>> src/subarray_sum_equals_k_counter.sv
// Channel     Direction  Handshake              Beat contents
// req_        in         req_valid / req_ready  element_value, array_start, array_end
// rsp_        out        rsp_valid / rsp_ready  match_total, table_overflow, final_result
// csr_        in         csr_write_en           target_sum (no read-back)
//
// One beat is taken every cycle while the result side drains; a beat is registered in
// the front stage, in each cell of the chain and in the tail's result register.
// Synchronous active-high reset clears all cell valid bits, the prefix, the total
// and the overflow flag, so the block is ready on the first cycle after reset.
// A stalled result beat freezes the whole chain; req_ready drops only then.
module subarray_sum_equals_k_counter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ssek_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ssek_pkg::rsp_type  rsp_data,
   input  logic               csr_write_en,
   input  logic [31:0]        csr_write_data
);

   // The chain moves as one: every stage shifts whenever the output
   // register is empty or its beat is being taken this cycle.
   logic advance;

   // chain[0] is the front stage output; chain[i+1] leaves cell i.
   ssek_pkg::beat_type chain [ssek_pkg::TABLE_ENTRIES+1];

   // The front stage keeps the running prefix and the target. It computes
   // the new prefix and the key to look up (prefix minus target) as the
   // beat enters, so every cell only compares and counts.
   ssek_front u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .beat_out       (chain[0])
   );

   // Each cell holds one table entry. A beat visits the cells in chain order,
   // and the beat behind it visits each cell only after it has moved on, so
   // every cell has already seen all earlier elements when a beat arrives.
   // Keys in the table are distinct, so at most one cell supplies the match
   // count, and at most one cell claims or bumps the current prefix.
   for (genvar i = 0; i < ssek_pkg::TABLE_ENTRIES; i++) begin : g_cell
      ssek_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .head_cell ((i == 0) ? 1'b1 : 1'b0),
         .beat_in   (chain[i]),
         .beat_out  (chain[i+1])
      );
   end

   // The tail adds the match count to the saturating total, records a
   // dropped prefix in the sticky overflow flag and holds the result beat.
   ssek_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .beat_in   (chain[ssek_pkg::TABLE_ENTRIES]),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .advance   (advance)
   );

   assign req_ready = advance;

endmodule

>>> src/ssek_front.sv
module ssek_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       req_valid,
   input  ssek_pkg::req_type          req_data,
   input  logic                       csr_write_en,
   input  logic [31:0]                csr_write_data,
   output ssek_pkg::beat_type         beat_out
);

   logic [ssek_pkg::DATA_WIDTH-1:0] prefix_ff, prefix_in;
   logic signed [31:0]              target_ff, target_in;
   ssek_pkg::beat_type              beat_ff, beat_in;

   logic [ssek_pkg::DATA_WIDTH-1:0] prefix_base;
   logic [ssek_pkg::DATA_WIDTH-1:0] want_sum;
   logic                            take;

   assign take = advance && req_valid;

   always_comb begin
      prefix_base = req_data.array_start ? '0 : prefix_ff;
      prefix_in   = prefix_ff;
      if (take) begin
         prefix_in = prefix_base + ssek_pkg::widen_elem(req_data.element_value);
      end
      want_sum = prefix_base + ssek_pkg::widen_elem(req_data.element_value)
                 - ssek_pkg::widen_elem(target_ff);
   end

   always_comb begin
      target_in = csr_write_en ? signed'(csr_write_data) : target_ff;
   end

   always_comb begin
      beat_in = beat_ff;
      if (advance) begin
         beat_in.valid  = req_valid;
         beat_in.start  = req_data.array_start;
         beat_in.last   = req_data.array_end;
         beat_in.prefix = prefix_base + ssek_pkg::widen_elem(req_data.element_value);
         beat_in.want   = want_sum;
         beat_in.match  = '0;
         beat_in.found  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         target_ff <= '0;
         beat_ff   <= '0;
      end else begin
         prefix_ff <= prefix_in;
         target_ff <= target_in;
         beat_ff   <= beat_in;
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> src/ssek_cell.sv
module ssek_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                head_cell,
   input  ssek_pkg::beat_type  beat_in,
   output ssek_pkg::beat_type  beat_out
);

   logic [ssek_pkg::DATA_WIDTH-1:0]  key_ff, key_in;
   logic [ssek_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                             valid_ff, valid_in;
   ssek_pkg::beat_type               beat_ff, beat_next;

   logic [ssek_pkg::DATA_WIDTH-1:0]  base_key;
   logic [ssek_pkg::COUNT_WIDTH-1:0] base_count;
   logic                             base_valid;
   logic                             want_hit;
   logic                             prefix_hit;

   always_comb begin
      // A new array wipes this cell; the head cell is seeded with prefix zero.
      if (beat_in.start) begin
         base_valid = head_cell;
         base_key   = '0;
         base_count = head_cell ? ssek_pkg::COUNT_WIDTH'(1) : '0;
      end else begin
         base_valid = valid_ff;
         base_key   = key_ff;
         base_count = count_ff;
      end

      want_hit   = base_valid && (base_key == beat_in.want);
      prefix_hit = base_valid && (base_key == beat_in.prefix);

      key_in    = key_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      beat_next = beat_ff;

      if (advance) begin
         beat_next = beat_in;
         if (beat_in.valid) begin
            key_in   = base_key;
            count_in = base_count;
            valid_in = base_valid;
            // Lookup uses the count as it stood before this element.
            if (want_hit) begin
               beat_next.match = base_count;
            end
            if (prefix_hit) begin
               beat_next.found = 1'b1;
               if (base_count != ssek_pkg::COUNT_MAX) begin
                  count_in = base_count + ssek_pkg::COUNT_WIDTH'(1);
               end
            end else if (!base_valid && !beat_in.found) begin
               // Cells fill from the head, so the first free cell is past all used ones.
               beat_next.found = 1'b1;
               key_in          = beat_in.prefix;
               count_in        = ssek_pkg::COUNT_WIDTH'(1);
               valid_in        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign beat_out = beat_ff;

endmodule

>>> src/ssek_tail.sv
module ssek_tail (
   input  logic                clock,
   input  logic                reset,
   input  ssek_pkg::beat_type  beat_in,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output ssek_pkg::rsp_type   rsp_data,
   output logic                advance
);

   logic [ssek_pkg::TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                             overflow_ff, overflow_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ssek_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic [ssek_pkg::TOTAL_WIDTH-1:0] base_total;
   logic [ssek_pkg::TOTAL_WIDTH:0]   sum;
   logic                             base_overflow;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      base_total    = beat_in.start ? '0 : total_ff;
      base_overflow = beat_in.start ? 1'b0 : overflow_ff;
      sum           = {1'b0, base_total} + (ssek_pkg::TOTAL_WIDTH + 1)'(beat_in.match);

      total_in     = total_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (advance) begin
         rsp_valid_in = beat_in.valid;
         if (beat_in.valid) begin
            total_in    = sum[ssek_pkg::TOTAL_WIDTH] ? ssek_pkg::TOTAL_MAX
                                                     : sum[ssek_pkg::TOTAL_WIDTH-1:0];
            overflow_in = base_overflow || !beat_in.found;
            rsp_data_in.match_total    = total_in;
            rsp_data_in.table_overflow = overflow_in;
            rsp_data_in.final_result   = beat_in.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
